@@ rtl/core/slpc_pkg.sv @@
// ----------------------------------------------------------------------------
// Stroke line/plus classifier package
// Shared types and constants: command codes, register indexes, widths and the
// structs that pass between the top level and the classifier.
// ----------------------------------------------------------------------------
package slpc_pkg;

   localparam int CoordWidth = 16;
   localparam int SumWidth   = 17;
   localparam int CountWidth = 16;

   // command codes carried in req_tuser
   localparam logic [1:0] CMD_FIRST   = 2'd0;
   localparam logic [1:0] CMD_FURTHER = 2'd1;
   localparam logic [1:0] CMD_LAST    = 2'd2;
   localparam logic [1:0] CMD_TICK    = 2'd3;

   // configuration register indexes
   localparam logic [1:0] REG_MIN_POINTS   = 2'd0;
   localparam logic [1:0] REG_ASPECT_RATIO = 2'd1;
   localparam logic [1:0] REG_TOL_FACTOR   = 2'd2;
   localparam logic [1:0] REG_EXPIRE_TICKS = 2'd3;

   localparam logic [9:0]  MIN_POINTS_RESET   = 10'd10;
   localparam logic [7:0]  ASPECT_RATIO_RESET = 8'd10;
   localparam logic [7:0]  TOL_FACTOR_RESET   = 8'd64;
   localparam logic [15:0] EXPIRE_TICKS_RESET = 16'd5000;

   typedef struct packed {
      logic [9:0]  min_points;
      logic [7:0]  aspect_ratio;
      logic [7:0]  tol_factor;
      logic [15:0] expire_ticks;
   } cfg_type;

   // box of the stroke as it stands after the item was applied
   typedef struct packed {
      logic [1:0]            cmd;
      logic [CoordWidth-1:0] low_x;
      logic [CoordWidth-1:0] high_x;
      logic [CoordWidth-1:0] low_y;
      logic [CoordWidth-1:0] high_y;
      logic [CountWidth-1:0] points;
   } box_snap_type;

   typedef struct packed {
      logic                  valid;
      logic                  horizontal;
      logic [SumWidth-1:0]   sum_x;
      logic [SumWidth-1:0]   sum_y;
      logic [CoordWidth-1:0] tol_x;
      logic [CoordWidth-1:0] tol_y;
   } kept_line_type;

   typedef struct packed {
      logic                  valid_line;
      logic                  horizontal;
      logic                  vertical;
      logic                  plus_sign;
      logic [CountWidth-1:0] point_count;
      logic [CoordWidth-1:0] box_width;
      logic [CoordWidth-1:0] box_height;
      logic [SumWidth-1:0]   center_x_doubled;
      logic [SumWidth-1:0]   center_y_doubled;
   } result_type;

endpackage

@@ rtl/core/slpc_classifier.sv @@
// ----------------------------------------------------------------------------
// Stroke classifier
// Classifies a finished stroke box by aspect ratio, computes its tolerances
// and tests it against the stored line for a plus sign.
// ----------------------------------------------------------------------------
module slpc_classifier (
   input  slpc_pkg::box_snap_type  snap,
   input  slpc_pkg::cfg_type       cfg,
   input  slpc_pkg::kept_line_type kept,
   input  logic [15:0]             age_ticks,
   output slpc_pkg::result_type    result,
   output slpc_pkg::kept_line_type kept_new
);

   logic [15:0] w_raw, h_raw, w, h;
   logic [16:0] sx, sy;
   logic [23:0] ar_h, ar_w, tol_w, tol_h;
   logic [15:0] tx, ty;
   logic        enough, hor, ver, valid, alive;
   logic [16:0] dx, dy;
   logic [15:0] htol_x, vtol_y;
   logic        plus;

   always_comb begin
      w_raw = snap.high_x - snap.low_x;
      h_raw = snap.high_y - snap.low_y;
      w     = (w_raw == 16'd0) ? 16'd1 : w_raw;
      h     = (h_raw == 16'd0) ? 16'd1 : h_raw;
      sx    = {1'b0, snap.low_x} + {1'b0, snap.high_x};
      sy    = {1'b0, snap.low_y} + {1'b0, snap.high_y};

      ar_h  = {16'd0, cfg.aspect_ratio} * {8'd0, h};
      ar_w  = {16'd0, cfg.aspect_ratio} * {8'd0, w};
      tol_w = {16'd0, cfg.tol_factor} * {8'd0, w};
      tol_h = {16'd0, cfg.tol_factor} * {8'd0, h};
      tx    = tol_w[23:8];
      ty    = tol_h[23:8];

      enough = snap.points >= {6'd0, cfg.min_points};
      hor    = enough && ({8'd0, w} >= ar_h);
      ver    = enough && !hor && ({8'd0, h} >= ar_w);
      valid  = hor || ver;

      // the stored line takes part only while unexpired
      alive  = kept.valid && (age_ticks < cfg.expire_ticks);
      dx     = (sx >= kept.sum_x) ? sx - kept.sum_x : kept.sum_x - sx;
      dy     = (sy >= kept.sum_y) ? sy - kept.sum_y : kept.sum_y - sy;
      htol_x = hor ? tx : kept.tol_x;
      vtol_y = hor ? kept.tol_y : ty;
      plus   = valid && alive && (kept.horizontal != hor)
               && (dx <= {htol_x, 1'b0}) && (dy <= {vtol_y, 1'b0});

      result.valid_line       = valid;
      result.horizontal       = hor;
      result.vertical         = ver;
      result.plus_sign        = plus;
      result.point_count      = snap.points;
      result.box_width        = w;
      result.box_height       = h;
      result.center_x_doubled = sx;
      result.center_y_doubled = sy;

      kept_new.valid      = 1'b1;
      kept_new.horizontal = hor;
      kept_new.sum_x      = sx;
      kept_new.sum_y      = sy;
      kept_new.tol_x      = tx;
      kept_new.tol_y      = ty;
   end

endmodule

@@ rtl/core/stroke_line_plus_classifier_unit.sv @@
// ----------------------------------------------------------------------------
// Stroke line and plus-sign classifier, top level
// A last-point item is held in the stage-one snapshot, then its result in the
// output register. Throughput: one item per cycle unless a last point waits on a
//   full, undrained output register; the box update and the classify stage overlap.
// Only last-point items make a result; first, further and tick items vanish.
// Reset (synchronous, active high) clears box, count, stored line and age,
//   loads register defaults and empties both pipeline stages.
// ----------------------------------------------------------------------------
module stroke_line_plus_classifier_unit (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] x, [31:16] y
   input  logic [1:0]  req_tuser,   // [1:0] command
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] point_count, [31:16] box_width, [47:32] box_height,
   // [64:48] center_x_doubled, [81:65] center_y_doubled, [87:82] zero
   output logic [87:0] rsp_tdata,
   // [0] valid_line, [1] horizontal, [2] vertical, [3] plus_sign
   output logic [3:0]  rsp_tuser,
   // configuration writes
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // ---- configuration registers ----
   slpc_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            slpc_pkg::REG_MIN_POINTS:   cfg_in.min_points   = csr_wdata[9:0];
            slpc_pkg::REG_ASPECT_RATIO: cfg_in.aspect_ratio = csr_wdata[7:0];
            slpc_pkg::REG_TOL_FACTOR:   cfg_in.tol_factor   = csr_wdata[7:0];
            slpc_pkg::REG_EXPIRE_TICKS: cfg_in.expire_ticks = csr_wdata;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_points   <= slpc_pkg::MIN_POINTS_RESET;
         cfg_ff.aspect_ratio <= slpc_pkg::ASPECT_RATIO_RESET;
         cfg_ff.tol_factor   <= slpc_pkg::TOL_FACTOR_RESET;
         cfg_ff.expire_ticks <= slpc_pkg::EXPIRE_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---- handshake and stage control ----
   logic req_accept;
   logic s1_valid_ff, s1_valid_in;
   logic s1_produces, adv_b;
   logic out_valid_ff, out_valid_in;

   slpc_pkg::box_snap_type s1_ff, s1_in;

   // A stage-one item that makes no result always moves on; a last point
   // waits only when the output register is full and not being drained.
   assign s1_produces = s1_valid_ff && (s1_ff.cmd == slpc_pkg::CMD_LAST);
   assign adv_b       = s1_valid_ff && (!s1_produces || !out_valid_ff || rsp_tready);
   assign req_tready  = !s1_valid_ff || adv_b;
   assign req_accept  = req_tvalid && req_tready;

   // ---- stage one: stroke box and point count ----
   logic [15:0] in_x, in_y;
   logic [15:0] low_x_ff, high_x_ff, low_y_ff, high_y_ff, points_ff;
   logic [15:0] low_x_in, high_x_in, low_y_in, high_y_in, points_in;

   assign in_x = req_tdata[15:0];
   assign in_y = req_tdata[31:16];

   always_comb begin
      low_x_in  = low_x_ff;
      high_x_in = high_x_ff;
      low_y_in  = low_y_ff;
      high_y_in = high_y_ff;
      points_in = points_ff;
      case (req_tuser)
         slpc_pkg::CMD_FIRST: begin
            // start a fresh box at this point
            low_x_in  = in_x;
            high_x_in = in_x;
            low_y_in  = in_y;
            high_y_in = in_y;
            points_in = 16'd1;
         end
         slpc_pkg::CMD_FURTHER, slpc_pkg::CMD_LAST: begin
            // grow the box; count saturates
            if (points_ff != 16'hFFFF) points_in = points_ff + 16'd1;
            if (in_x < low_x_ff)  low_x_in  = in_x;
            if (in_x > high_x_ff) high_x_in = in_x;
            if (in_y < low_y_ff)  low_y_in  = in_y;
            if (in_y > high_y_ff) high_y_in = in_y;
         end
         default: ;
      endcase

      s1_in.cmd    = req_tuser;
      s1_in.low_x  = low_x_in;
      s1_in.high_x = high_x_in;
      s1_in.low_y  = low_y_in;
      s1_in.high_y = high_y_in;
      s1_in.points = points_in;

      if (req_accept)  s1_valid_in = 1'b1;
      else if (adv_b)  s1_valid_in = 1'b0;
      else             s1_valid_in = s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_x_ff    <= '0;
         high_x_ff   <= '0;
         low_y_ff    <= '0;
         high_y_ff   <= '0;
         points_ff   <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (req_accept) begin
            low_x_ff  <= low_x_in;
            high_x_ff <= high_x_in;
            low_y_ff  <= low_y_in;
            high_y_ff <= high_y_in;
            points_ff <= points_in;
         end
      end
   end

   // snapshot is payload: no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) s1_ff <= s1_in;
   end

   // ---- stage two: classify, plus test, stored line ----
   slpc_pkg::kept_line_type kept_ff, kept_in, kept_new;
   slpc_pkg::result_type    result, out_ff;
   logic [15:0]             age_ff, age_in;

   slpc_classifier u_classifier (
      .snap      (s1_ff),
      .cfg       (cfg_ff),
      .kept      (kept_ff),
      .age_ticks (age_ff),
      .result    (result),
      .kept_new  (kept_new)
   );

   always_comb begin
      kept_in = kept_ff;
      age_in  = age_ff;
      if (adv_b) begin
         if (s1_produces && result.valid_line) begin
            // a new valid line always replaces the stored one
            kept_in = kept_new;
            age_in  = 16'd0;
         end else if (s1_ff.cmd == slpc_pkg::CMD_TICK && age_ff != 16'hFFFF) begin
            age_in = age_ff + 16'd1;
         end
      end

      if (adv_b && s1_produces) out_valid_in = 1'b1;
      else if (rsp_tready)      out_valid_in = 1'b0;
      else                      out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kept_ff      <= '0;
         age_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         kept_ff      <= kept_in;
         age_ff       <= age_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_b && s1_produces) out_ff <= result;
   end

   // ---- result port ----
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = {out_ff.plus_sign, out_ff.vertical, out_ff.horizontal,
                        out_ff.valid_line};
   assign rsp_tdata  = {6'd0, out_ff.center_y_doubled, out_ff.center_x_doubled,
                        out_ff.box_height, out_ff.box_width, out_ff.point_count};

endmodule

@@ rtl/core/slpc_checker.sv @@
// ----------------------------------------------------------------------------
// Stroke classifier port checker
// Watches the top-level ports for result consistency and handshake rules.
// ----------------------------------------------------------------------------
module slpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [87:0] rsp_tdata,
   input logic [3:0]  rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // a line is exactly one orientation; no line means no orientation, no plus
   a_orient: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] == (rsp_tuser[1] ^ rsp_tuser[2]))
                     && !(rsp_tuser[1] && rsp_tuser[2]))
      else $error("line flag and orientation disagree");

   a_plus: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[3] |-> rsp_tuser[0])
      else $error("plus sign without a valid line");

   // box sides are clamped to at least one
   a_box: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[31:16] != 16'd0) && (rsp_tdata[47:32] != 16'd0))
      else $error("zero box side reported");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind stroke_line_plus_classifier_unit slpc_checker u_slpc_checker (.*);

@@ sim/tb_stroke_line_plus_classifier_unit.sv @@
// ----------------------------------------------------------------------------
// Stroke line and plus-sign classifier testbench
// Streams touch strokes, ticks and stray points into the classifier and checks
// every verdict against a cycle-free predictor of the box, aspect-ratio and
// plus-sign logic. Phases vary the register settings and the idling of both
// stream sides.
// ----------------------------------------------------------------------------
module tb_stroke_line_plus_classifier_unit;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int  CYCLE_LIMIT  = 1_000_000;
   localparam int  DRAIN_CYCLES = 6;    // margin for the pipeline to clear
   localparam int  PHASE_ITEMS  = 200;
   localparam int  NUM_PHASES   = 8;
   localparam int  MAX_REPORTS  = 40;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] x;
      logic [15:0] y;
   } touch_type;

   // every input of the block is known from time zero
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;    // [15:0] x, [31:16] y
   logic [1:0]  req_tuser  = slpc_pkg::CMD_TICK; // [1:0] command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [15:0] point_count, [31:16] box_width, [47:32] box_height,
   // [64:48] center_x_doubled, [81:65] center_y_doubled, [87:82] zero
   logic [87:0] rsp_tdata;
   logic [3:0]  rsp_tuser;          // [0] valid_line, [1] horizontal,
                                    // [2] vertical, [3] plus_sign
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = slpc_pkg::REG_MIN_POINTS;
   logic [15:0] csr_wdata  = '0;

   stroke_line_plus_classifier_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // -------------------------------------------------------------------------
   // Predictor state: the register copy, the open stroke and the stored line.
   // All of it starts at the reset values of the block.
   // -------------------------------------------------------------------------
   logic [9:0]  cfg_min_points = slpc_pkg::MIN_POINTS_RESET;
   logic [7:0]  cfg_aspect     = slpc_pkg::ASPECT_RATIO_RESET;
   logic [7:0]  cfg_tol        = slpc_pkg::TOL_FACTOR_RESET;
   logic [15:0] cfg_expire     = slpc_pkg::EXPIRE_TICKS_RESET;

   logic [15:0] box_lo_x = '0, box_hi_x = '0, box_lo_y = '0, box_hi_y = '0;
   logic [15:0] stroke_points = '0;
   logic        line_kept = 1'b0, line_kept_hor = 1'b0;
   logic [16:0] line_sum_x = '0, line_sum_y = '0;
   logic [15:0] line_tol_x = '0, line_tol_y = '0;
   logic [15:0] line_age = '0;

   touch_type            pending_touches[$];   // items waiting for the driver
   slpc_pkg::result_type expected_verdicts[$]; // verdicts waiting for the block

   int error_count = 0;
   int cycle_count = 0;
   int phase_count = 0;      // items queued in the current phase
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;

   // stimulus-side memory of the last line stroke, used to aim crossings
   bit gen_have_line = 1'b0;
   bit gen_upright   = 1'b0;
   int gen_cx = 0, gen_cy = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Checking helpers
   // -------------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      // count every mismatch, but keep the log short
      if (error_count < MAX_REPORTS) $display("%0t ns: mismatch: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   function automatic int unsigned abs_gap(input int unsigned a, input int unsigned b);
      return (a >= b) ? a - b : b - a;
   endfunction

   // extend the open stroke by one point, count saturating
   function automatic void grow_box(input logic [15:0] x, input logic [15:0] y);
      if (stroke_points != 16'hFFFF) stroke_points++;
      if (x < box_lo_x) box_lo_x = x;
      if (x > box_hi_x) box_hi_x = x;
      if (y < box_lo_y) box_lo_y = y;
      if (y > box_hi_y) box_hi_y = y;
   endfunction

   // Advance the predicted state by one accepted item; a last point queues
   // the verdict the block must produce for it.
   function automatic void classify_touch(input logic [1:0] cmd, input logic [15:0] x,
                                          input logic [15:0] y);
      int unsigned          span_x, span_y, sum_x, sum_y, tol_x, tol_y, htol, vtol;
      bit                   hor, ver, alive, plus;
      slpc_pkg::result_type verdict;
      hor  = 1'b0;
      ver  = 1'b0;
      plus = 1'b0;
      case (cmd)
         slpc_pkg::CMD_FIRST: begin
            box_lo_x = x;
            box_hi_x = x;
            box_lo_y = y;
            box_hi_y = y;
            stroke_points = 16'd1;
         end
         slpc_pkg::CMD_FURTHER: grow_box(x, y);
         slpc_pkg::CMD_TICK: begin
            if (line_age != 16'hFFFF) line_age++;
         end
         default: begin
            grow_box(x, y);
            span_x = 32'(box_hi_x) - 32'(box_lo_x);
            span_y = 32'(box_hi_y) - 32'(box_lo_y);
            if (span_x < 1) span_x = 1;
            if (span_y < 1) span_y = 1;
            sum_x = 32'(box_lo_x) + 32'(box_hi_x);
            sum_y = 32'(box_lo_y) + 32'(box_hi_y);
            // horizontal wins when both tests pass (aspect ratio zero, or one on a square box)
            if (stroke_points >= 16'(cfg_min_points)) begin
               if (span_x >= 32'(cfg_aspect) * span_y) hor = 1'b1;
               else if (span_y >= 32'(cfg_aspect) * span_x) ver = 1'b1;
            end
            if (hor || ver) begin
               tol_x = (span_x * 32'(cfg_tol)) >> 8;
               tol_y = (span_y * 32'(cfg_tol)) >> 8;
               alive = line_kept && (line_age < cfg_expire);
               if (alive && (line_kept_hor != hor)) begin
                  // x tolerance from the horizontal line, y from the vertical
                  htol = hor ? tol_x : 32'(line_tol_x);
                  vtol = hor ? 32'(line_tol_y) : tol_y;
                  plus = (abs_gap(sum_x, 32'(line_sum_x)) <= 2 * htol) &&
                         (abs_gap(sum_y, 32'(line_sum_y)) <= 2 * vtol);
               end
               // a new line always replaces the stored one
               line_kept     = 1'b1;
               line_kept_hor = hor;
               line_sum_x    = sum_x[16:0];
               line_sum_y    = sum_y[16:0];
               line_tol_x    = tol_x[15:0];
               line_tol_y    = tol_y[15:0];
               line_age      = '0;
            end
            verdict.valid_line       = hor || ver;
            verdict.horizontal       = hor;
            verdict.vertical         = ver;
            verdict.plus_sign        = plus;
            verdict.point_count      = stroke_points;
            verdict.box_width        = span_x[15:0];
            verdict.box_height       = span_y[15:0];
            verdict.center_x_doubled = sum_x[16:0];
            verdict.center_y_doubled = sum_y[16:0];
            expected_verdicts.push_back(verdict);
         end
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Driver: hold an item until accepted, predict it on acceptance, then
   // advance to the next pending item or idle.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : driver
      touch_type next;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            classify_touch(req_tuser, req_tdata[15:0], req_tdata[31:16]);
         if (!req_tvalid || req_tready) begin
            if (pending_touches.size() != 0 &&
                $urandom_range(99) >= sender_idle_pct) begin
               next = pending_touches.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {next.y, next.x};
               req_tuser  <= next.cmd;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: stall at random, compare each accepted verdict with the oldest
   // expectation field by field.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      slpc_pkg::result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch("verdict arrived with nothing expected");
            end else begin
               want = expected_verdicts.pop_front();
               check_field("valid_line", rsp_tuser[0], want.valid_line);
               check_field("horizontal", rsp_tuser[1], want.horizontal);
               check_field("vertical", rsp_tuser[2], want.vertical);
               check_field("plus_sign", rsp_tuser[3], want.plus_sign);
               check_field("point_count", rsp_tdata[15:0], want.point_count);
               check_field("box_width", rsp_tdata[31:16], want.box_width);
               check_field("box_height", rsp_tdata[47:32], want.box_height);
               check_field("center_x_doubled", rsp_tdata[64:48], want.center_x_doubled);
               check_field("center_y_doubled", rsp_tdata[81:65], want.center_y_doubled);
            end
         end
      end
   end

   // give up on a hung block
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus builders
   // -------------------------------------------------------------------------
   task automatic push_touch(input logic [1:0] cmd, input int x, input int y);
      touch_type t;
      t.cmd = cmd;
      t.x   = x[15:0];
      t.y   = y[15:0];
      pending_touches.push_back(t);
      phase_count++;
   endtask

   function automatic int clamp_coord(input int v);
      return (v < 0) ? 0 : ((v > 65535) ? 65535 : v);
   endfunction

   // One stroke whose box is fixed by its first and last points, so the
   // doubled centroid is exact unless the box hits the screen edge. A stroke
   // of one point is a lone last point that extends the held box.
   task automatic push_stroke(input bit upright, input int cx, input int cy,
                              input int half_len, input int half_thick, input int npts);
      int lo_x, hi_x, lo_y, hi_y, i;
      if (upright) begin
         lo_x = cx - half_thick;
         hi_x = cx + half_thick;
         lo_y = cy - half_len;
         hi_y = cy + half_len;
      end else begin
         lo_x = cx - half_len;
         hi_x = cx + half_len;
         lo_y = cy - half_thick;
         hi_y = cy + half_thick;
      end
      lo_x = clamp_coord(lo_x);
      hi_x = clamp_coord(hi_x);
      lo_y = clamp_coord(lo_y);
      hi_y = clamp_coord(hi_y);
      if (npts > 1) push_touch(slpc_pkg::CMD_FIRST, lo_x, lo_y);
      for (i = 1; i < npts - 1; i++) begin
         // a stray tick mid-stroke must not disturb the box
         if ($urandom_range(99) < 3) push_touch(slpc_pkg::CMD_TICK, $urandom, $urandom);
         push_touch(slpc_pkg::CMD_FURTHER, $urandom_range(hi_x, lo_x),
                    $urandom_range(hi_y, lo_y));
      end
      push_touch(slpc_pkg::CMD_LAST, hi_x, hi_y);
   endtask

   function automatic int pick_half_len();
      int r;
      r = $urandom_range(9);
      if (r < 3) return $urandom_range(50, 1);
      if (r < 8) return $urandom_range(3000, 50);
      return $urandom_range(30000, 3000);
   endfunction

   // point count near the threshold, now and then below it
   function automatic int pick_points();
      if (cfg_min_points <= 1) return $urandom_range(8, 2);
      if ($urandom_range(4) == 0) return $urandom_range(cfg_min_points - 1, 1);
      return cfg_min_points + $urandom_range(3);
   endfunction

   // Line-shaped stroke; half the time aim it across the last line, with an
   // offset that lands inside the tolerance about as often as outside.
   task automatic add_line_stroke();
      int hl, ht, cx, cy, reach;
      bit upright;
      hl = pick_half_len();
      if ($urandom_range(4) != 0) ht = $urandom_range(hl / (cfg_aspect + 1));
      else ht = $urandom_range(hl);
      if (gen_have_line && $urandom_range(1)) begin
         upright = !gen_upright;
         reach   = hl / 4 + 1;
         cx = gen_cx;
         cy = gen_cy;
         if ($urandom_range(2) != 0) begin
            cx = cx + int'($urandom_range(2 * reach)) - reach;
            cy = cy + int'($urandom_range(2 * reach)) - reach;
         end
      end else begin
         upright = $urandom_range(1);
         cx = $urandom_range(65535);
         cy = $urandom_range(65535);
      end
      push_stroke(upright, cx, cy, hl, ht, pick_points());
      gen_have_line = 1'b1;
      gen_upright   = upright;
      gen_cx        = cx;
      gen_cy        = cy;
   endtask

   // ticks: around the expiry edge half the time when that is short, otherwise one to four
   task automatic add_ticks();
      int n, i;
      if (cfg_expire <= 400 && $urandom_range(1)) begin
         n = int'(cfg_expire) + int'($urandom_range(4)) - 2;
         if (n < 1) n = 1;
      end else begin
         n = $urandom_range(4, 1);
      end
      for (i = 0; i < n; i++) push_touch(slpc_pkg::CMD_TICK, $urandom, $urandom);
   endtask

   // broken input: points with no first point, or a fully random item
   task automatic add_noise();
      int k, i;
      if ($urandom_range(1)) begin
         k = $urandom_range(3);
         for (i = 0; i < k; i++) push_touch(slpc_pkg::CMD_FURTHER, $urandom, $urandom);
         push_touch(slpc_pkg::CMD_LAST, $urandom, $urandom);
      end else begin
         push_touch($urandom_range(3), $urandom, $urandom);
      end
   endtask

   task automatic fill_random(input int budget);
      int roll, hl;
      phase_count = 0;
      while (phase_count < budget) begin
         roll = $urandom_range(99);
         if (roll < 55) begin
            add_line_stroke();
         end else if (roll < 70) begin
            hl = pick_half_len();
            push_stroke($urandom_range(1), $urandom_range(65535), $urandom_range(65535),
                        hl, $urandom_range(hl), pick_points());
         end else if (roll < 82) begin
            add_ticks();
         end else begin
            add_noise();
         end
      end
   endtask

   // Directed opening at reset settings (10 points, ratio 10, factor 64).
   task automatic push_directed();
      int i;
      // lone last point: grows the zero box left by reset, too few points
      push_touch(slpc_pkg::CMD_LAST, 65535, 0);
      // full-width horizontal line, flat, exactly ten points
      push_touch(slpc_pkg::CMD_FIRST, 0, 100);
      for (i = 1; i <= 8; i++) push_touch(slpc_pkg::CMD_FURTHER, i * 8000, 100);
      push_touch(slpc_pkg::CMD_LAST, 65535, 100);
      push_touch(slpc_pkg::CMD_TICK, 0, 0);
      // vertical crossing it: y offset sits exactly on the tolerance limit
      push_touch(slpc_pkg::CMD_FIRST, 32767, 0);
      for (i = 1; i <= 8; i++) push_touch(slpc_pkg::CMD_FURTHER, 32768, i * 50);
      push_touch(slpc_pkg::CMD_LAST, 32768, 400);
      // corner-to-corner box with too few points
      push_touch(slpc_pkg::CMD_FIRST, 40000, 20000);
      push_touch(slpc_pkg::CMD_FURTHER, 0, 65535);
      push_touch(slpc_pkg::CMD_LAST, 65535, 0);
   endtask

   // hold until every item is in and every verdict is out, then let any
   // result-free item clear the pipeline
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_touches.size() != 0 || req_tvalid || expected_verdicts.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write all four registers, with junk above the minimum-points and aspect-ratio fields.
   task automatic program_regs(input int unsigned min_pts, input int unsigned ratio,
                               input int unsigned factor, input int unsigned expire);
      logic [1:0]  idx[4];
      logic [15:0] word[4];
      logic [5:0]  junk_hi;
      logic [7:0]  junk_lo;
      int          i;
      junk_hi = $urandom;
      junk_lo = $urandom;
      idx[0]  = slpc_pkg::REG_MIN_POINTS;
      idx[1]  = slpc_pkg::REG_ASPECT_RATIO;
      idx[2]  = slpc_pkg::REG_TOL_FACTOR;
      idx[3]  = slpc_pkg::REG_EXPIRE_TICKS;
      word[0] = {junk_hi, min_pts[9:0]};
      word[1] = {junk_lo, ratio[7:0]};
      word[2] = {8'h00, factor[7:0]};
      word[3] = expire[15:0];
      for (i = 0; i < 4; i++) begin
         @(posedge clock);
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= word[i];
         case (idx[i])
            slpc_pkg::REG_MIN_POINTS:   cfg_min_points = word[i][9:0];
            slpc_pkg::REG_ASPECT_RATIO: cfg_aspect     = word[i][7:0];
            slpc_pkg::REG_TOL_FACTOR:   cfg_tol        = word[i][7:0];
            default:                    cfg_expire     = word[i];
         endcase
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Sequencer: reset once, then run the phases. Each later phase changes the
   // registers (extremes among them) and the idling pattern.
   // -------------------------------------------------------------------------
   initial begin : sequencer
      int phase;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase > 0) wait_drained();
         case (phase)
            1: program_regs(3, 1, 255, 20);
            2: program_regs(0, 0, 0, 0);      // everything classifies, all horizontal
            3: program_regs(1023, 255, 128, 1);
            4: program_regs(5, 2, 64, 65535);
            5: program_regs(1, 4, 200, 8);
            6: program_regs(6, 3, 100, 50);
            7: program_regs(2, 8, 32, 300);
            default: ;                        // reset settings stand
         endcase
         case (phase % 4)
            1: begin
               sender_idle_pct    = 50;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 50;
            end
            3: begin
               sender_idle_pct    = 22;
               receiver_stall_pct = 22;
            end
            default: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
         endcase
         if (phase == 0) push_directed();
         fill_random(PHASE_ITEMS);
      end
      wait_drained();
      if (expected_verdicts.size() != 0)
         report_mismatch($sformatf("%0d verdicts never arrived", expected_verdicts.size()));
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
